### src/vn_pkg.sv
// vn_pkg: widths, payload types and derived sizes for the vector normalizer
// used by the channel interfaces, the top level and the checker
package vn_pkg;
	localparam int COMP_W  = 32;            // significant bits of one component
	localparam int FRAC_W  = 30;            // fraction bits of a unit component
	localparam int FIELD_W = 32;            // width of a payload field
	localparam int SUM_W   = 2 * COMP_W;    // exact squared length
	localparam int ROOT_W  = SUM_W / 2;     // integer square root
	localparam int REM_W   = ROOT_W + 4;    // square root partial remainder
	localparam int QUO_W   = FRAC_W + 1;    // quotient bits, up to 2^FRAC_W
	localparam int DREM_W  = COMP_W + 2;    // divider partial remainder

	typedef struct packed {
		logic signed [FIELD_W-1:0] vec_x;
		logic signed [FIELD_W-1:0] vec_y;
		logic signed [FIELD_W-1:0] vec_z;
	} vec_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] unit_x;
		logic signed [FIELD_W-1:0] unit_y;
		logic signed [FIELD_W-1:0] unit_z;
		logic                      zero_length;
	} unit_t;
endpackage

### src/vn_vec_if.sv
// vn_vec_if: valid/ready channel carrying one input vector
// depends on vn_pkg
interface vn_vec_if;
	import vn_pkg::*;
	logic valid;
	logic ready;
	vec_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/vn_unit_if.sv
// vn_unit_if: valid/ready channel carrying one normalized vector
// depends on vn_pkg
interface vn_unit_if;
	import vn_pkg::*;
	logic  valid;
	logic  ready;
	unit_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/vector3_normalize_top.sv
// channel   | dir | payload                                   | handshake
// vec_in    | in  | vec_x, vec_y, vec_z (signed Q16.16)       | valid/ready
// unit_out  | out | unit_x, unit_y, unit_z (Q2.30), zero_length | valid/ready
//
// one request per cycle sustained unless unit_out stalls. the square root
// yields one result bit and the divider one quotient bit per stage. reset
// clears only the stage valid bits. a stall on unit_out freezes the whole
// pipeline together, so nothing is dropped or repeated.
// depends on vn_pkg, vn_vec_if, vn_unit_if
module vector3_normalize_top (
	input  logic clk,
	input  logic arst_n,
	vn_vec_if.sink    vec_in,
	vn_unit_if.source unit_out
);
	import vn_pkg::*;

	typedef struct packed {
		logic [SUM_W-1:0]         rad;
		logic [REM_W-1:0]         rem;
		logic [ROOT_W-1:0]        root;
		logic [2:0][COMP_W-1:0]   mag;
		logic [2:0]               neg;
		logic                     zero;
	} rt_t;

	typedef struct packed {
		logic [2:0][DREM_W-1:0]   drem;
		logic [2:0][QUO_W-1:0]    quo;
		logic [ROOT_W-1:0]        len;
		logic [2:0]               neg;
		logic                     zero;
	} dv_t;

	logic                   adv;
	logic [2:0][COMP_W-1:0] comp;
	logic [2:0][COMP_W-1:0] mag_s1;
	logic [2:0]             neg_s1;
	logic                   vld_s1;
	logic [2:0][SUM_W-1:0]  sqr_s2;
	logic [2:0][COMP_W-1:0] mag_s2;
	logic [2:0]             neg_s2;
	logic                   zero_s2;
	logic                   vld_s2;
	rt_t                    rt_s [0:ROOT_W];
	logic                   rt_vld_s [0:ROOT_W];
	dv_t                    dv_in;
	logic                   dv_in_vld;
	dv_t                    dv_s [1:QUO_W];
	logic                   dv_vld_s [1:QUO_W];
	unit_t                  res_s;
	logic                   res_vld_s;

	// whole pipeline moves unless the result register is held
	assign adv = !res_vld_s || unit_out.ready;
	assign vec_in.ready = adv;

	assign comp[0] = vec_in.data.vec_x[COMP_W-1:0];
	assign comp[1] = vec_in.data.vec_y[COMP_W-1:0];
	assign comp[2] = vec_in.data.vec_z[COMP_W-1:0];

	// stage 1: magnitudes and signs
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= comp[i][COMP_W-1];
				mag_s1[i] <= comp[i][COMP_W-1] ? (~comp[i] + 1'b1) : comp[i];
			end
		end
	end

	// stage 2: squares and zero detect
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sqr_s2[i] <= SUM_W'(mag_s1[i]) * SUM_W'(mag_s1[i]);
			end
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			zero_s2 <= (mag_s1[0] == '0) && (mag_s1[1] == '0) && (mag_s1[2] == '0);
		end
	end

	// stage 3: squared length
	always_ff @(posedge clk) begin
		if (adv) begin
			rt_s[0].rad  <= sqr_s2[0] + sqr_s2[1] + sqr_s2[2];
			rt_s[0].rem  <= '0;
			rt_s[0].root <= '0;
			rt_s[0].mag  <= mag_s2;
			rt_s[0].neg  <= neg_s2;
			rt_s[0].zero <= zero_s2;
		end
	end

	// valid bits for the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			rt_vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s1      <= vec_in.valid;
			vld_s2      <= vld_s1;
			rt_vld_s[0] <= vld_s2;
		end
	end

	// square root: one result bit per stage, two radicand bits consumed
	for (genvar k = 0; k < ROOT_W; k++) begin : g_rt
		logic [REM_W-1:0] rem_sh;
		logic [REM_W-1:0] trial;
		logic             ge;

		always_comb begin
			rem_sh = {rt_s[k].rem[REM_W-3:0], rt_s[k].rad[SUM_W-1 -: 2]};
			trial  = REM_W'({rt_s[k].root, 2'b01});
			ge     = rem_sh >= trial;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rt_s[k+1].rad  <= {rt_s[k].rad[SUM_W-3:0], 2'b00};
				rt_s[k+1].rem  <= ge ? (rem_sh - trial) : rem_sh;
				rt_s[k+1].root <= {rt_s[k].root[ROOT_W-2:0], ge};
				rt_s[k+1].mag  <= rt_s[k].mag;
				rt_s[k+1].neg  <= rt_s[k].neg;
				rt_s[k+1].zero <= rt_s[k].zero;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				rt_vld_s[k+1] <= rt_vld_s[k];
			end
		end
	end

	// divider entry: magnitude over length, no register of its own
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dv_in.drem[i] = DREM_W'(rt_s[ROOT_W].mag[i]);
			dv_in.quo[i]  = '0;
		end
		dv_in.len  = rt_s[ROOT_W].root;
		dv_in.neg  = rt_s[ROOT_W].neg;
		dv_in.zero = rt_s[ROOT_W].zero;
		dv_in_vld  = rt_vld_s[ROOT_W];
	end

	// restoring divide: one quotient bit per stage in three lanes
	for (genvar j = 0; j < QUO_W; j++) begin : g_dv
		dv_t                    cur;
		logic                   cur_vld;
		logic [2:0][DREM_W-1:0] diff;
		logic [2:0]             ge;

		// stage input: divider entry first, then the previous stage
		if (j == 0) begin : g_head
			assign cur     = dv_in;
			assign cur_vld = dv_in_vld;
		end else begin : g_body
			assign cur     = dv_s[j];
			assign cur_vld = dv_vld_s[j];
		end

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				ge[i]   = cur.drem[i] >= DREM_W'(cur.len);
				diff[i] = ge[i] ? (cur.drem[i] - DREM_W'(cur.len)) : cur.drem[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int i = 0; i < 3; i++) begin
					dv_s[j+1].drem[i] <= {diff[i][DREM_W-2:0], 1'b0};
					dv_s[j+1].quo[i]  <= {cur.quo[i][QUO_W-2:0], ge[i]};
				end
				dv_s[j+1].len  <= cur.len;
				dv_s[j+1].neg  <= cur.neg;
				dv_s[j+1].zero <= cur.zero;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[j+1] <= 1'b0;
			end else if (adv) begin
				dv_vld_s[j+1] <= cur_vld;
			end
		end
	end

	// output: clamp, restore sign, force zero vector result
	logic [2:0][FIELD_W-1:0] mag_out;
	logic [2:0][FIELD_W-1:0] signed_out;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_out[i] = (dv_s[QUO_W].quo[i] > QUO_W'(1 << FRAC_W)) ?
				FIELD_W'(1 << FRAC_W) : FIELD_W'(dv_s[QUO_W].quo[i]);
			if (dv_s[QUO_W].zero) begin
				signed_out[i] = '0;
			end else if (dv_s[QUO_W].neg[i]) begin
				signed_out[i] = ~mag_out[i] + 1'b1;
			end else begin
				signed_out[i] = mag_out[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s.unit_x      <= signed_out[0];
			res_s.unit_y      <= signed_out[1];
			res_s.unit_z      <= signed_out[2];
			res_s.zero_length <= dv_s[QUO_W].zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_s <= 1'b0;
		end else if (adv) begin
			res_vld_s <= dv_vld_s[QUO_W];
		end
	end

	assign unit_out.valid = res_vld_s;
	assign unit_out.data  = res_s;
endmodule

### src/vn_checker.sv
// vn_checker: port-level assertions for the vector normalizer, with its bind
// depends on vn_pkg and vector3_normalize_top
module vn_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [vn_pkg::FIELD_W-1:0] unit_x,
	input logic signed [vn_pkg::FIELD_W-1:0] unit_y,
	input logic signed [vn_pkg::FIELD_W-1:0] unit_z,
	input logic                          zero_length
);
	import vn_pkg::*;

	localparam logic signed [FIELD_W-1:0] ONE  = FIELD_W'(1 << FRAC_W);
	localparam logic signed [FIELD_W-1:0] MONE = -ONE;

	// held request keeps its valid
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result request dropped while stalled");

	// held request keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({unit_x, unit_y, unit_z, zero_length}))
		else $error("result payload changed while stalled");

	// zero vector gives zero components
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_length |-> unit_x == 0 && unit_y == 0 && unit_z == 0)
		else $error("zero vector with nonzero components");

	// components stay within plus or minus one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> unit_x <= ONE && unit_x >= MONE && unit_y <= ONE &&
			unit_y >= MONE && unit_z <= ONE && unit_z >= MONE)
		else $error("unit component out of range");
endmodule

bind vector3_normalize_top vn_checker u_vn_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (unit_out.valid),
	.out_ready   (unit_out.ready),
	.unit_x      (unit_out.data.unit_x),
	.unit_y      (unit_out.data.unit_y),
	.unit_z      (unit_out.data.unit_z),
	.zero_length (unit_out.data.zero_length)
);
